// ===== sv/aftm_pkg.sv =====
// Shared types, coefficients and pipeline depths for the fitted ACES tone curve unit.
// No dependencies; aftm_lane, aftm_merge and the top unit in this folder import it.
package aftm_pkg;

    typedef logic [23:0] chan_t;
    typedef logic [23:0] coef_t;
    typedef logic signed [25:0] ocoef_t;
    typedef logic [16:0] res_t;

    localparam int DIV_BITS  = 26;
    localparam int LANE_LAT  = 5 + DIV_BITS;
    localparam int MERGE_LAT = 2;
    localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

    // curve coefficients, Q.24
    localparam logic [23:0] CURVE_A = 24'd412360;
    localparam logic [23:0] CURVE_B = 24'd1519;
    localparam logic [23:0] CURVE_C = 24'd16504234;
    localparam logic [23:0] CURVE_D = 24'd7263712;
    localparam logic [23:0] CURVE_E = 24'd3994336;

    localparam res_t ONE_Q16 = 17'd65536;

    localparam coef_t IN_MAT [3][3] = '{
        '{24'd10019186, 24'd5948865,  24'd809165},
        '{24'd1275068,  24'd15239416, 24'd262731},
        '{24'd476473,   24'd2245295,  24'd14055448}
    };

    localparam ocoef_t OUT_MAT [3][3] = '{
        '{26'sd26923237, -26'sd8910044,  -26'sd1235978},
        '{-26'sd1712618, 26'sd18591336,  -26'sd101502},
        '{-26'sd54861,   -26'sd1220710,  26'sd18052620}
    };

    // one long-division stage
    typedef struct packed {
        logic [41:0]         rem;
        logic [41:0]         den;
        logic [DIV_BITS-1:0] q;
        logic [1:0]          lowb;
        logic                neg;
    } div_t;

endpackage

// ===== sv/aftm_pix_if.sv =====
// Input pixel channel: valid/ready handshake with RGB Q8.16 and alpha.
// No dependencies.
interface aftm_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] red_in;
    logic [23:0] green_in;
    logic [23:0] blue_in;
    logic [15:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// ===== sv/aftm_tone_if.sv =====
// Output pixel channel: valid/ready handshake with RGB Q1.16 and alpha.
// No dependencies.
interface aftm_tone_if;
    logic        valid;
    logic        ready;
    logic [16:0] red_out;
    logic [16:0] green_out;
    logic [16:0] blue_out;
    logic [15:0] alpha_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

// ===== sv/aftm_lane.sv =====
// One colour lane: input matrix row, fitted rational curve, pipelined long division.
// Depends on aftm_pkg.
module aftm_lane (
    input  logic            clk,
    input  logic            en,
    input  aftm_pkg::coef_t coef [3],
    input  aftm_pkg::chan_t x [3],
    output logic signed [26:0] y
);
    import aftm_pkg::*;

    logic [47:0] prod_reg [3];
    logic [31:0] v_reg;
    logic [31:0] v2_reg;
    logic [55:0] cv_reg;
    logic [47:0] tlo_reg;
    logic [48:0] thi_reg;
    logic [47:0] wlo_reg;
    logic [48:0] whi_reg;
    div_t        div_reg [DIV_BITS+1];

    logic [49:0] sum;
    logic [32:0] t;
    logic [32:0] w;
    logic [64:0] tfull;
    logic [64:0] pfull;
    logic [41:0] denv;
    logic [41:0] pv;
    logic        neg;
    logic [41:0] mag;

    always_comb
    begin
        sum = 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(prod_reg[2]) + 50'd32768;
        t = 33'(cv_reg[55:24]) + 33'(CURVE_D);
        w = 33'(v2_reg) + 33'(CURVE_A);
        tfull = 65'(tlo_reg) + {thi_reg, 16'd0};
        pfull = 65'(wlo_reg) + {whi_reg, 16'd0};
        denv = 42'(tfull[64:24]) + 42'(CURVE_E);
        pv = 42'(pfull[64:24]);
        neg = pv < 42'(CURVE_B);
        mag = neg ? (42'(CURVE_B) - pv) : (pv - 42'(CURVE_B));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= coef[j] * x[j];
            end
            // round half up to Q.24
            v_reg <= sum[47:16];
            cv_reg <= CURVE_C * v_reg;
            v2_reg <= v_reg;
            tlo_reg <= v2_reg * t[15:0];
            thi_reg <= v2_reg * t[32:16];
            wlo_reg <= v2_reg * w[15:0];
            whi_reg <= v2_reg * w[32:16];
            div_reg[0].rem <= {2'd0, mag[41:2]};
            div_reg[0].den <= denv;
            div_reg[0].q <= '0;
            div_reg[0].lowb <= mag[1:0];
            div_reg[0].neg <= neg;
        end
    end

    // one quotient bit per stage; dividend is mag << 24
    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        logic        bit_in;
        logic [42:0] shifted;
        logic [42:0] diff;
        logic        ge;

        always_comb
        begin
            bit_in = (k == 0) ? div_reg[k].lowb[1] :
                     ((k == 1) ? div_reg[k].lowb[0] : 1'b0);
            shifted = {div_reg[k].rem, bit_in};
            ge = shifted >= {1'b0, div_reg[k].den};
            diff = shifted - {1'b0, div_reg[k].den};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k+1].rem <= ge ? diff[41:0] : shifted[41:0];
                div_reg[k+1].den <= div_reg[k].den;
                div_reg[k+1].q <= {div_reg[k].q[DIV_BITS-2:0], ge};
                div_reg[k+1].lowb <= div_reg[k].lowb;
                div_reg[k+1].neg <= div_reg[k].neg;
            end
        end
    end

    assign y = div_reg[DIV_BITS].neg ? -$signed({1'b0, div_reg[DIV_BITS].q})
                                     : $signed({1'b0, div_reg[DIV_BITS].q});

endmodule

// ===== sv/aftm_merge.sv =====
// Output matrix across the three lanes, rounding and clamp to Q1.16.
// Depends on aftm_pkg.
module aftm_merge (
    input  logic               clk,
    input  logic               en,
    input  logic signed [26:0] y [3],
    output aftm_pkg::res_t     r [3]
);
    import aftm_pkg::*;

    logic signed [52:0] prod_reg [3][3];
    res_t               r_reg [3];

    function automatic res_t clamp(input logic signed [52:0] a, input logic signed [52:0] b,
                                   input logic signed [52:0] c);
        logic signed [54:0] acc;
        logic signed [54:0] rnd;
        logic [22:0]        rv;
        acc = 55'(a) + 55'(b) + 55'(c);
        rnd = acc + 55'sh80000000;
        rv = rnd[54:32];
        if (acc <= 0)
            return '0;
        else if (rv > 23'(ONE_Q16))
            return ONE_Q16;
        else
            return rv[16:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= OUT_MAT[i][j] * y[j];
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= clamp(prod_reg[i][0], prod_reg[i][1], prod_reg[i][2]);
            end
        end
    end

    assign r = r_reg;

endmodule

// ===== sv/aces_fitted_tonemap_pixel_unit.sv =====
// Fitted ACES tone curve, one pixel per clock while the skid buffer is empty. The path from
// input beat to output valid: 5 matrix/curve stages, 26 divider stages (one quotient bit each),
// 2 output-matrix stages and the output register.
// A two-entry output buffer (output register plus skid) keeps ready off the output path.
// Asynchronous active-low reset clears the valid bits only; no other state.
module aces_fitted_tonemap_pixel_unit (
    input  logic              clk,
    input  logic              rst_n,
    aftm_pix_if.sink          pix,
    aftm_tone_if.source       tone
);
    import aftm_pkg::*;

    logic        en;
    logic        vld_reg [PIPE_LAT];
    logic [15:0] alpha_reg [PIPE_LAT];
    chan_t       x [3];
    logic signed [26:0] y [3];
    res_t        r [3];

    logic        out_vld_reg;
    logic        skid_vld_reg;
    res_t        out_r_reg [3];
    logic [15:0] out_a_reg;
    res_t        skid_r_reg [3];
    logic [15:0] skid_a_reg;
    logic        last_vld;

    assign en = !skid_vld_reg;
    assign pix.ready = en;
    assign last_vld = vld_reg[PIPE_LAT-1];

    assign x[0] = pix.red_in;
    assign x[1] = pix.green_in;
    assign x[2] = pix.blue_in;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        aftm_lane u_lane (
            .clk  (clk),
            .en   (en),
            .coef (IN_MAT[i]),
            .x    (x),
            .y    (y[i])
        );
    end

    aftm_merge u_merge (
        .clk (clk),
        .en  (en),
        .y   (y),
        .r   (r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_LAT; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg[0] <= pix.valid;
                for (int s = 1; s < PIPE_LAT; s++)
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
                if (!out_vld_reg || tone.ready)
                    out_vld_reg <= last_vld;
                else if (last_vld)
                    skid_vld_reg <= 1'b1;
            end
            else if (tone.ready)
            begin
                out_vld_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg[0] <= pix.alpha_in;
            for (int s = 1; s < PIPE_LAT; s++)
            begin
                alpha_reg[s] <= alpha_reg[s-1];
            end
            if (!out_vld_reg || tone.ready)
            begin
                out_r_reg <= r;
                out_a_reg <= alpha_reg[PIPE_LAT-1];
            end
            else
            begin
                skid_r_reg <= r;
                skid_a_reg <= alpha_reg[PIPE_LAT-1];
            end
        end
        else if (tone.ready)
        begin
            out_r_reg <= skid_r_reg;
            out_a_reg <= skid_a_reg;
        end
    end

    assign tone.valid = out_vld_reg;
    assign tone.red_out = out_r_reg[0];
    assign tone.green_out = out_r_reg[1];
    assign tone.blue_out = out_r_reg[2];
    assign tone.alpha_out = out_a_reg;

    // skid holds a beat only behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid full with output empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(last_vld && out_vld_reg && !tone.ready))
        else $error("skid filled without a stalled beat");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && tone.ready) |=> (!skid_vld_reg && out_vld_reg))
        else $error("skid beat not moved to output");

endmodule

// ===== tb/tb_aces_fitted_tonemap_pixel_unit.sv =====
// Testbench for the fitted ACES tone curve pixel unit: directed and random pixels,
// predicted in-bench and checked beat by beat. Depends on aftm_pkg, both interfaces and the unit.
module tb_aces_fitted_tonemap_pixel_unit;
    import aftm_pkg::*;

    typedef struct packed {
        logic [23:0] r;
        logic [23:0] g;
        logic [23:0] b;
        logic [15:0] a;
    } pix_t;

    typedef struct packed {
        logic [16:0] r;
        logic [16:0] g;
        logic [16:0] b;
        logic [15:0] a;
    } tone_t;

    logic clk;
    logic rst_n;
    aftm_pix_if  pix ();
    aftm_tone_if tone ();

    aces_fitted_tonemap_pixel_unit uut (.clk(clk), .rst_n(rst_n), .pix(pix), .tone(tone));

    pix_t  pending_pix [$];
    tone_t expected_tone [$];
    int    errors = 0;
    int    beats_in = 0;
    int    beats_out = 0;
    int    calm_lo;
    int    calm_hi;
    logic  in_taken;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // exact floor(u*w / 2^24)
    function automatic logic [63:0] q24_mul(input logic [63:0] u, input logic [63:0] w);
        logic [127:0] p;
        p = u * w;
        return p[87:24];
    endfunction

    function automatic logic signed [63:0] tone_curve(input logic [63:0] v);
        logic [63:0] den;
        logic [63:0] p;
        logic [63:0] mag;
        logic [95:0] q;
        logic        neg;
        den = q24_mul(v, q24_mul(64'(CURVE_C), v) + 64'(CURVE_D)) + 64'(CURVE_E);
        p   = q24_mul(v, v + 64'(CURVE_A));
        neg = p < 64'(CURVE_B);
        mag = neg ? 64'(CURVE_B) - p : p - 64'(CURVE_B);
        q   = {mag, 24'd0} / 96'(den);
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic tone_t tonemap(input pix_t px);
        logic [23:0]        x [3];
        logic signed [63:0] y [3];
        logic [63:0]        s;
        logic signed [63:0] acc;
        logic [63:0]        r [3];
        tone_t              t;
        x = '{px.r, px.g, px.b};
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += 64'(IN_MAT[i][j]) * 64'(x[j]);
            y[i] = tone_curve((s + 64'd32768) >> 16);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += 64'(OUT_MAT[i][j]) * y[j];
            if (acc <= 0)
                r[i] = 0;
            else
            begin
                r[i] = (acc + 64'h8000_0000) >> 32;
                if (r[i] > 64'(ONE_Q16))
                    r[i] = 64'(ONE_Q16);
            end
        end
        t.r = r[0][16:0];
        t.g = r[1][16:0];
        t.b = r[2][16:0];
        t.a = px.a;
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("mismatch %s at beat %0d: got %0d want %0d", what, beats_out, got, want);
        errors++;
    endtask

    function automatic bit idle_now();
        if (beats_in >= calm_lo && beats_in < calm_hi)
            return 1'b0;
        return $urandom_range(99) < 14;
    endfunction

    // input beat taken at the rising edge; ready may change right after it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= pix.valid && pix.ready;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid    <= 1'b0;
            pix.red_in   <= '0;
            pix.green_in <= '0;
            pix.blue_in  <= '0;
            pix.alpha_in <= '0;
        end
        else
        begin
            if (in_taken)
            begin
                void'(pending_pix.pop_front());
                beats_in <= beats_in + 1;
            end
            if (in_taken || !pix.valid)
            begin
                if (pending_pix.size() > 0 && !idle_now())
                begin
                    pix.valid    <= 1'b1;
                    pix.red_in   <= pending_pix[0].r;
                    pix.green_in <= pending_pix[0].g;
                    pix.blue_in  <= pending_pix[0].b;
                    pix.alpha_in <= pending_pix[0].a;
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // sink ready, random stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tone.ready <= 1'b0;
        else
            tone.ready <= !((beats_out < calm_lo || beats_out >= calm_hi)
                            && $urandom_range(99) < 14);
    end

    // input monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
            expected_tone.push_back(tonemap('{pix.red_in, pix.green_in, pix.blue_in,
                                              pix.alpha_in}));
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && tone.valid && tone.ready)
        begin
            tone_t w;
            if (expected_tone.size() == 0)
                report_mismatch("unexpected beat", tone.red_out, 17'd0);
            else
            begin
                w = expected_tone.pop_front();
                if (tone.red_out !== w.r)
                    report_mismatch("red", tone.red_out, w.r);
                if (tone.green_out !== w.g)
                    report_mismatch("green", tone.green_out, w.g);
                if (tone.blue_out !== w.b)
                    report_mismatch("blue", tone.blue_out, w.b);
                if (tone.alpha_out !== w.a)
                    report_mismatch("alpha", {1'b0, tone.alpha_out}, {1'b0, w.a});
            end
            beats_out <= beats_out + 1;
        end
    end

    function automatic logic [23:0] rand_chan();
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(4095));
            2: return 24'($urandom_range(262143));
            3: return 24'($urandom_range(2097151));
            4: return 24'($urandom_range(16777215, 8388608));
            default: return 24'($urandom_range(131071));
        endcase
    endfunction

    initial begin
        logic [23:0] edges [6];
        calm_lo   = 250;
        calm_hi   = 330;
        rst_n     = 1'b0;
        // zero, tiny (negative curve numerator), small, one, large, full scale
        edges = '{24'd0, 24'd1, 24'd64, 24'd65536, 24'd1048576, 24'hFFFFFF};
        for (int i = 0; i < 6; i++)
            pending_pix.push_back('{edges[i], edges[i], edges[i],
                                    i[0] ? 16'hFFFF : 16'h0000});
        // single hot channel, others zero or full: pushes output matrix negative
        for (int i = 0; i < 3; i++)
        begin
            pending_pix.push_back('{i == 0 ? 24'hFFFFFF : 24'd0, i == 1 ? 24'hFFFFFF : 24'd0,
                                    i == 2 ? 24'hFFFFFF : 24'd0, 16'h5A5A});
            pending_pix.push_back('{i == 0 ? 24'd0 : 24'hFFFFFF, i == 1 ? 24'd0 : 24'hFFFFFF,
                                    i == 2 ? 24'd0 : 24'hFFFFFF, 16'hA5A5});
            pending_pix.push_back('{i == 0 ? 24'd300 : 24'd0, i == 1 ? 24'd300 : 24'd0,
                                    i == 2 ? 24'd300 : 24'd0, 16'h0001});
        end
        for (int i = 0; i < 550; i++)
            pending_pix.push_back('{rand_chan(), rand_chan(), rand_chan(),
                                    16'($urandom)});
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_pix.size() == 0);
        wait (expected_tone.size() == 0);
        repeat (PIPE_LAT + 20) @(posedge clk);
        $display("covered %0d pixels: edge values, single-channel extremes, random ranges",
                 beats_in);
        if (errors == 0)
            $display("[aces_fitted_tonemap_pixel_unit] OK");
        else
            $display("[aces_fitted_tonemap_pixel_unit] ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("[aces_fitted_tonemap_pixel_unit] ERROR");
        $finish;
    end
endmodule

// ===== aces_fitted_tonemap_pixel_unit.f =====
sv/aftm_pkg.sv
sv/aftm_pix_if.sv
sv/aftm_tone_if.sv
sv/aftm_lane.sv
sv/aftm_merge.sv
sv/aces_fitted_tonemap_pixel_unit.sv
tb/tb_aces_fitted_tonemap_pixel_unit.sv
